FILE: rtl/core/gaps_pkg.sv
// Shared types and constants of the grid path search block.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package gaps_pkg;

  // Internal coordinate width: holds any tile of the largest grid plus one step
  localparam int CRD_W = 9;
  // Path cost width (g and f scores)
  localparam int COST_W = 24;

  // Result status codes
  typedef enum logic [2:0] {
    ST_STEP     = 3'd0,
    ST_SAME     = 3'd1,
    ST_UNREACH  = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_TOOLONG  = 3'd4
  } status_e;

  // List scan kinds
  typedef enum logic [1:0] {
    SK_BEST, // lowest f in the open list
    SK_CNB,  // neighbour in the closed list
    SK_ONB,  // neighbour in the open list, plus first free slot
    SK_CPAR  // parent of the current tile in the closed list
  } scan_e;

  // Controller states
  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHK,
    S_BEST0, S_BEST, S_BEST_E, S_POP,
    S_NB, S_NB_M,
    S_CS, S_CS_E, S_CS_D,
    S_OS, S_OS_E, S_OS_D,
    S_WK, S_WS, S_WS_E, S_WS_D,
    S_EM0, S_ERD, S_ELD,
    S_ERR
  } state_e;

  // Open list entry
  typedef struct packed {
    logic [CRD_W-1:0]  x;
    logic [CRD_W-1:0]  y;
    logic [CRD_W-1:0]  px;
    logic [CRD_W-1:0]  py;
    logic [COST_W-1:0] g;
    logic [COST_W-1:0] f;
  } node_t;

  // Closed list entry
  typedef struct packed {
    logic [CRD_W-1:0] x;
    logic [CRD_W-1:0] y;
    logic [CRD_W-1:0] px;
    logic [CRD_W-1:0] py;
  } cnode_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    in_ready;
    logic    map_clr;
    logic    map_wr;
    logic    latch;
    logic    init;
    logic    scan_clr;
    logic    scan;
    scan_e   scan_kind;
    logic    pop;
    logic    nb_next;
    logic    open_upd;
    logic    open_new;
    logic    walk_init;
    logic    walk_push;
    logic    walk_load;
    logic    emit_init;
    logic    emit_next;
    logic    out_step;
    logic    out_err;
    status_e err_code;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic same;
    logic scan_end;
    logic hit;
    logic free;
    logic hit_goal;
    logic closed_full;
    logic nb_out;
    logic nb_blocked;
    logic k_last;
    logic cheaper;
    logic cur_start;
    logic n_zero;
    logic n_full;
    logic e_zero;
    logic out_full;
  } sts_t;

  // Unscaled Manhattan distance between two tiles
  function automatic logic [CRD_W:0] manhattan(input logic [CRD_W-1:0] ax,
                                               input logic [CRD_W-1:0] ay,
                                               input logic [CRD_W-1:0] bx,
                                               input logic [CRD_W-1:0] by);
    logic [CRD_W-1:0] dx;
    logic [CRD_W-1:0] dy;
    dx = (ax > bx) ? ax - bx : bx - ax;
    dy = (ay > by) ? ay - by : by - ay;
    return {1'b0, dx} + {1'b0, dy};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/gaps_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module gaps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/core/gaps_ctrl.sv
// Controller state machine of the grid path search block.
// Depends on gaps_pkg; drives the datapath through cmd_t and reads sts_t.
`default_nettype none

module gaps_ctrl import gaps_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  input  wire logic in_func_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e  state_q, state_d;
  status_e err_q, err_d;

  // State and error code registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      err_q   <= ST_STEP;
    end else begin
      state_q <= state_d;
      err_q   <= err_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    err_d   = err_q;
    case (state_q)
      S_CLEAR: begin
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i && in_func_i) state_d = S_CHK;
      end
      S_CHK: begin
        if (sts_i.same) begin
          state_d = S_ERR;
          err_d   = ST_SAME;
        end else begin
          state_d = S_BEST0;
        end
      end
      S_BEST0:  state_d = S_BEST;
      S_BEST: begin
        if (sts_i.scan_end) state_d = S_BEST_E;
      end
      S_BEST_E: state_d = S_POP;
      S_POP: begin
        if (!sts_i.hit) begin
          state_d = S_ERR;
          err_d   = ST_UNREACH;
        end else if (sts_i.closed_full) begin
          state_d = S_ERR;
          err_d   = ST_OVERFLOW;
        end else if (sts_i.hit_goal) begin
          state_d = S_WK;
        end else begin
          state_d = S_NB;
        end
      end
      S_NB: begin
        if (sts_i.nb_out) state_d = sts_i.k_last ? S_BEST0 : S_NB;
        else              state_d = S_NB_M;
      end
      S_NB_M: begin
        if (sts_i.nb_blocked) state_d = sts_i.k_last ? S_BEST0 : S_NB;
        else                  state_d = S_CS;
      end
      S_CS: begin
        if (sts_i.scan_end) state_d = S_CS_E;
      end
      S_CS_E: state_d = S_CS_D;
      S_CS_D: begin
        if (sts_i.hit) state_d = sts_i.k_last ? S_BEST0 : S_NB;
        else           state_d = S_OS;
      end
      S_OS: begin
        if (sts_i.scan_end) state_d = S_OS_E;
      end
      S_OS_E: state_d = S_OS_D;
      S_OS_D: begin
        if (sts_i.hit || sts_i.free) begin
          state_d = sts_i.k_last ? S_BEST0 : S_NB;
        end else begin
          state_d = S_ERR;
          err_d   = ST_OVERFLOW;
        end
      end
      S_WK: begin
        if (sts_i.cur_start) begin
          if (sts_i.n_zero) begin
            state_d = S_ERR;
            err_d   = ST_UNREACH;
          end else begin
            state_d = S_EM0;
          end
        end else if (sts_i.n_full) begin
          state_d = S_ERR;
          err_d   = ST_TOOLONG;
        end else begin
          state_d = S_WS;
        end
      end
      S_WS: begin
        if (sts_i.scan_end) state_d = S_WS_E;
      end
      S_WS_E: state_d = S_WS_D;
      S_WS_D: begin
        if (sts_i.hit) begin
          state_d = S_WK;
        end else begin
          state_d = S_ERR;
          err_d   = ST_UNREACH;
        end
      end
      S_EM0: state_d = S_ERD;
      S_ERD: state_d = S_ELD;
      S_ELD: begin
        if (!sts_i.out_full) state_d = sts_i.e_zero ? S_IDLE : S_ERD;
      end
      S_ERR: begin
        if (!sts_i.out_full) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o           = '0;
    cmd_o.scan_kind = SK_BEST;
    cmd_o.err_code  = err_q;
    case (state_q)
      S_CLEAR: cmd_o.map_clr = 1'b1;
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        cmd_o.map_wr   = in_valid_i && !in_func_i;
        cmd_o.latch    = in_valid_i && in_func_i;
      end
      S_CHK:   cmd_o.init     = !sts_i.same;
      S_BEST0: cmd_o.scan_clr = 1'b1;
      S_BEST: begin
        cmd_o.scan      = 1'b1;
        cmd_o.scan_kind = SK_BEST;
      end
      S_POP: begin
        cmd_o.pop       = sts_i.hit && !sts_i.closed_full;
        cmd_o.walk_init = sts_i.hit && !sts_i.closed_full && sts_i.hit_goal;
      end
      S_NB: cmd_o.nb_next = sts_i.nb_out;
      S_NB_M: begin
        cmd_o.nb_next  = sts_i.nb_blocked;
        cmd_o.scan_clr = !sts_i.nb_blocked;
      end
      S_CS: begin
        cmd_o.scan      = 1'b1;
        cmd_o.scan_kind = SK_CNB;
      end
      S_CS_D: begin
        cmd_o.nb_next  = sts_i.hit;
        cmd_o.scan_clr = !sts_i.hit;
      end
      S_OS: begin
        cmd_o.scan      = 1'b1;
        cmd_o.scan_kind = SK_ONB;
      end
      S_OS_D: begin
        cmd_o.open_upd = sts_i.hit && sts_i.cheaper;
        cmd_o.open_new = !sts_i.hit && sts_i.free;
        cmd_o.nb_next  = sts_i.hit || sts_i.free;
      end
      S_WK: begin
        cmd_o.emit_init = sts_i.cur_start && !sts_i.n_zero;
        cmd_o.walk_push = !sts_i.cur_start && !sts_i.n_full;
        cmd_o.scan_clr  = !sts_i.cur_start && !sts_i.n_full;
      end
      S_WS: begin
        cmd_o.scan      = 1'b1;
        cmd_o.scan_kind = SK_CPAR;
      end
      S_WS_D: cmd_o.walk_load = sts_i.hit;
      S_ELD: begin
        cmd_o.out_step  = !sts_i.out_full;
        cmd_o.emit_next = !sts_i.out_full && !sts_i.e_zero;
      end
      S_ERR: cmd_o.out_err = !sts_i.out_full;
      default: cmd_o.scan_kind = SK_BEST;
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/gaps_dp.sv
// Datapath of the grid path search block: tile map, open and closed lists,
// path buffer, list scanner and result register. Depends on gaps_pkg, gaps_ram.
`default_nettype none

module gaps_dp import gaps_pkg::*; #(
  parameter int GRID_SIDE  = 32,
  parameter int LIST_DEPTH = 256,
  parameter int MAX_PATH   = 64,
  parameter int STEP_COST  = 10
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cmd_t       cmd_i,
  output sts_t            sts_o,
  input  wire logic [4:0] cell_x_i,
  input  wire logic [4:0] cell_y_i,
  input  wire logic       cell_blocked_i,
  input  wire logic [4:0] start_x_i,
  input  wire logic [4:0] start_y_i,
  input  wire logic [4:0] goal_x_i,
  input  wire logic [4:0] goal_y_i,
  input  wire logic       out_ready_i,
  output logic            out_valid_o,
  output logic [4:0]      step_x_o,
  output logic [4:0]      step_y_o,
  output logic            last_o,
  output logic [2:0]      status_o
);

  localparam int MAP_DEPTH = GRID_SIDE * GRID_SIDE;
  localparam int MAW = $clog2(MAP_DEPTH);
  localparam int LAW = $clog2(LIST_DEPTH);
  localparam int PAW = (MAX_PATH > 1) ? $clog2(MAX_PATH) : 1;
  localparam int NW  = $clog2(MAX_PATH + 1);
  localparam logic [CRD_W-1:0]  GSIDE     = CRD_W'(GRID_SIDE);
  localparam logic [COST_W-1:0] COST_STEP = COST_W'(STEP_COST);

  // Control registers
  logic [MAW-1:0]        mcnt_q;
  logic [LAW-1:0]        cnt_q;
  logic                  ev_q;
  scan_e                 ev_kind_q;
  logic                  ev_used_q;
  logic [LAW-1:0]        ev_idx_q;
  logic                  hit_q;
  logic [LAW-1:0]        hit_idx_q;
  logic                  free_q;
  logic [LAW-1:0]        free_idx_q;
  logic [LIST_DEPTH-1:0] used_q;
  logic [LAW:0]          ccnt_q;
  logic [1:0]            k_q;
  logic [NW-1:0]         n_q;
  logic [NW-1:0]         e_q;
  logic                  out_v_q;

  // Payload registers
  logic [CRD_W-1:0] sx_q, sy_q, gx_q, gy_q;
  node_t            hit_e_q;
  node_t            cur_q;
  logic [4:0]       out_x_q, out_y_q;
  logic             out_last_q;
  status_e          out_st_q;

  // Memory ports
  logic           map_we, map_wdata, map_rd;
  logic [MAW-1:0] map_waddr, nb_addr, wr_addr;
  logic           open_we;
  logic [LAW-1:0] open_waddr;
  node_t          open_wdata, open_rd;
  cnode_t         closed_wdata, closed_rd;
  logic [9:0]     pb_wdata, pb_rd;

  // Combinational helpers
  logic [CRD_W-1:0]  nb_x, nb_y;
  logic              nb_low, nb_out, wr_in;
  logic [COST_W-1:0] ng, h_nb, h_start;
  logic [LAW:0]      ccnt_m1;
  logic [LAW-1:0]    lim;
  logic              ev_hit, ev_free;
  node_t             ev_ent;

  // Neighbour of the current tile in the order +y, +x, -y, -x
  always_comb begin
    nb_x   = cur_q.x;
    nb_y   = cur_q.y;
    nb_low = 1'b0;
    case (k_q)
      2'd0: nb_y = cur_q.y + 1'b1;
      2'd1: nb_x = cur_q.x + 1'b1;
      2'd2: begin
        nb_y   = cur_q.y - 1'b1;
        nb_low = (cur_q.y == '0);
      end
      default: begin
        nb_x   = cur_q.x - 1'b1;
        nb_low = (cur_q.x == '0);
      end
    endcase
  end

  assign nb_out  = nb_low || (nb_x >= GSIDE) || (nb_y >= GSIDE);
  assign nb_addr = MAW'(nb_y * GRID_SIDE + nb_x);
  assign wr_addr = MAW'(cell_y_i * GRID_SIDE + cell_x_i);
  assign wr_in   = (CRD_W'(cell_x_i) < GSIDE) && (CRD_W'(cell_y_i) < GSIDE);

  // Costs
  assign ng      = cur_q.g + COST_STEP;
  assign h_nb    = COST_W'(manhattan(nb_x, nb_y, gx_q, gy_q)) * COST_STEP;
  assign h_start = COST_W'(manhattan(sx_q, sy_q, gx_q, gy_q)) * COST_STEP;

  // Scan limit: whole open list, or the filled part of the closed list
  assign ccnt_m1 = ccnt_q - 1'b1;
  always_comb begin
    case (cmd_i.scan_kind)
      SK_BEST, SK_ONB: lim = LAW'(LIST_DEPTH - 1);
      default:         lim = ccnt_m1[LAW-1:0];
    endcase
  end

  // Evaluate the entry read in the previous cycle
  always_comb begin
    ev_hit  = 1'b0;
    ev_free = 1'b0;
    ev_ent  = open_rd;
    case (ev_kind_q)
      SK_BEST: ev_hit = ev_used_q && (!hit_q || (open_rd.f < hit_e_q.f));
      SK_ONB: begin
        ev_hit  = ev_used_q && !hit_q && (open_rd.x == nb_x) && (open_rd.y == nb_y);
        ev_free = !ev_used_q && !free_q;
      end
      SK_CNB: begin
        ev_hit = !hit_q && (closed_rd.x == nb_x) && (closed_rd.y == nb_y);
        ev_ent = '{x: closed_rd.x, y: closed_rd.y, px: closed_rd.px, py: closed_rd.py,
                   g: '0, f: '0};
      end
      default: begin
        ev_hit = !hit_q && (closed_rd.x == cur_q.px) && (closed_rd.y == cur_q.py);
        ev_ent = '{x: closed_rd.x, y: closed_rd.y, px: closed_rd.px, py: closed_rd.py,
                   g: '0, f: '0};
      end
    endcase
    ev_hit  = ev_hit && ev_q;
    ev_free = ev_free && ev_q;
  end

  // Tile map port selection: clearing pass or cell write
  assign map_we    = cmd_i.map_clr || (cmd_i.map_wr && wr_in);
  assign map_waddr = cmd_i.map_clr ? mcnt_q : wr_addr;
  assign map_wdata = cmd_i.map_clr ? 1'b0 : cell_blocked_i;

  // Open list write: start entry, cheaper path, or new entry
  always_comb begin
    open_we    = cmd_i.init || cmd_i.open_upd || cmd_i.open_new;
    open_waddr = '0;
    open_wdata = '{x: sx_q, y: sy_q, px: sx_q, py: sy_q, g: '0, f: h_start};
    if (cmd_i.open_upd) begin
      open_waddr = hit_idx_q;
      open_wdata = '{x: hit_e_q.x, y: hit_e_q.y, px: cur_q.x, py: cur_q.y, g: ng,
                     f: hit_e_q.f - hit_e_q.g + ng};
    end else if (cmd_i.open_new) begin
      open_waddr = free_idx_q;
      open_wdata = '{x: nb_x, y: nb_y, px: cur_q.x, py: cur_q.y, g: ng, f: ng + h_nb};
    end
  end

  assign closed_wdata = '{x: hit_e_q.x, y: hit_e_q.y, px: hit_e_q.px, py: hit_e_q.py};
  assign pb_wdata     = {cur_q.y[4:0], cur_q.x[4:0]};

  gaps_ram #(.WIDTH(1), .DEPTH(MAP_DEPTH)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (nb_addr),
    .rdata_o (map_rd)
  );

  gaps_ram #(.WIDTH($bits(node_t)), .DEPTH(LIST_DEPTH)) u_open (
    .clk_i   (clk_i),
    .we_i    (open_we),
    .waddr_i (open_waddr),
    .wdata_i (open_wdata),
    .raddr_i (cnt_q),
    .rdata_o (open_rd)
  );

  gaps_ram #(.WIDTH($bits(cnode_t)), .DEPTH(LIST_DEPTH)) u_closed (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pop),
    .waddr_i (ccnt_q[LAW-1:0]),
    .wdata_i (closed_wdata),
    .raddr_i (cnt_q),
    .rdata_o (closed_rd)
  );

  gaps_ram #(.WIDTH(10), .DEPTH(MAX_PATH)) u_path (
    .clk_i   (clk_i),
    .we_i    (cmd_i.walk_push),
    .waddr_i (n_q[PAW-1:0]),
    .wdata_i (pb_wdata),
    .raddr_i (e_q[PAW-1:0]),
    .rdata_o (pb_rd)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcnt_q     <= '0;
      cnt_q      <= '0;
      ev_q       <= 1'b0;
      ev_kind_q  <= SK_BEST;
      ev_used_q  <= 1'b0;
      ev_idx_q   <= '0;
      hit_q      <= 1'b0;
      hit_idx_q  <= '0;
      free_q     <= 1'b0;
      free_idx_q <= '0;
      used_q     <= '0;
      ccnt_q     <= '0;
      k_q        <= '0;
      n_q        <= '0;
      e_q        <= '0;
      out_v_q    <= 1'b0;
    end else begin
      // Clearing pass over the tile map
      if (cmd_i.map_clr) mcnt_q <= mcnt_q + 1'b1;
      // Issue one list read per cycle, evaluate it in the next
      ev_q <= cmd_i.scan;
      if (cmd_i.scan) begin
        cnt_q     <= cnt_q + 1'b1;
        ev_kind_q <= cmd_i.scan_kind;
        ev_used_q <= used_q[cnt_q];
        ev_idx_q  <= cnt_q;
      end
      if (cmd_i.scan_clr) begin
        cnt_q  <= '0;
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end else begin
        if (ev_hit) begin
          hit_q     <= 1'b1;
          hit_idx_q <= ev_idx_q;
        end
        if (ev_free) begin
          free_q     <= 1'b1;
          free_idx_q <= ev_idx_q;
        end
      end
      // List occupancy
      if (cmd_i.init) begin
        used_q <= LIST_DEPTH'(1);
        ccnt_q <= '0;
      end
      if (cmd_i.pop) begin
        used_q[hit_idx_q] <= 1'b0;
        ccnt_q            <= ccnt_q + 1'b1;
        k_q               <= '0;
      end
      if (cmd_i.open_new) used_q[free_idx_q] <= 1'b1;
      if (cmd_i.nb_next)  k_q <= k_q + 1'b1;
      // Path walk and emission counters
      if (cmd_i.walk_init) n_q <= '0;
      if (cmd_i.walk_push) n_q <= n_q + 1'b1;
      if (cmd_i.emit_init) e_q <= n_q - 1'b1;
      if (cmd_i.emit_next) e_q <= e_q - 1'b1;
      // Result register: drop on transfer, load on command
      if (out_v_q && out_ready_i) out_v_q <= 1'b0;
      if (cmd_i.out_step || cmd_i.out_err) out_v_q <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      sx_q <= CRD_W'(start_x_i);
      sy_q <= CRD_W'(start_y_i);
      gx_q <= CRD_W'(goal_x_i);
      gy_q <= CRD_W'(goal_y_i);
    end
    if (!cmd_i.scan_clr && ev_hit) hit_e_q <= ev_ent;
    if (cmd_i.pop)       cur_q <= hit_e_q;
    if (cmd_i.walk_load) cur_q <= hit_e_q;
    if (cmd_i.out_step) begin
      out_x_q    <= pb_rd[4:0];
      out_y_q    <= pb_rd[9:5];
      out_last_q <= (e_q == '0);
      out_st_q   <= ST_STEP;
    end else if (cmd_i.out_err) begin
      out_x_q    <= '0;
      out_y_q    <= '0;
      out_last_q <= 1'b1;
      out_st_q   <= cmd_i.err_code;
    end
  end

  // Status to the controller
  always_comb begin
    sts_o.clr_done    = (mcnt_q == MAW'(MAP_DEPTH - 1));
    sts_o.same        = (sx_q == gx_q) && (sy_q == gy_q);
    sts_o.scan_end    = (cnt_q == lim);
    sts_o.hit         = hit_q;
    sts_o.free        = free_q;
    sts_o.hit_goal    = (hit_e_q.x == gx_q) && (hit_e_q.y == gy_q);
    sts_o.closed_full = (ccnt_q == (LAW+1)'(LIST_DEPTH));
    sts_o.nb_out      = nb_out;
    sts_o.nb_blocked  = map_rd;
    sts_o.k_last      = (k_q == 2'd3);
    sts_o.cheaper     = (ng < hit_e_q.g);
    sts_o.cur_start   = (cur_q.x == sx_q) && (cur_q.y == sy_q);
    sts_o.n_zero      = (n_q == '0);
    sts_o.n_full      = (n_q == NW'(MAX_PATH));
    sts_o.e_zero      = (e_q == '0);
    sts_o.out_full    = out_v_q;
  end

  assign out_valid_o = out_v_q;
  assign step_x_o    = out_x_q;
  assign step_y_o    = out_y_q;
  assign last_o      = out_last_q;
  assign status_o    = out_st_q;

endmodule

`default_nettype wire

FILE: rtl/core/grid_astar_path_search.sv
// Grid A* path search. After reset the tile map is cleared, one tile per cycle,
// before the first item is taken. A map write is taken while the block is idle
// and leaves it ready for the next item. A search is sequential: each expansion
// scans the open list, and each free neighbour scans the closed list and, if it
// is not closed, the open list; the walk back scans the closed list once per
// path step, then each step leaves only after the previous one was taken.
`default_nettype none

module grid_astar_path_search import gaps_pkg::*; #(
  parameter int GRID_SIDE  = 32,
  parameter int LIST_DEPTH = 256,
  parameter int MAX_PATH   = 64,
  parameter int STEP_COST  = 10
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // tdata: cell_x[4:0], cell_y[9:5], cell_blocked[10], start_x[15:11],
  //        start_y[20:16], goal_x[25:21], goal_y[30:26], zero pad [31]
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [31:0] s_axis_tdata_i,
  // tuser: func[0]
  input  wire logic        s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: step_x[4:0], step_y[9:5], zero pad [15:10]
  output logic [15:0]      m_axis_tdata_o,
  // tuser: status[2:0]
  output logic [2:0]       m_axis_tuser_o,
  output logic             m_axis_tlast_o
);

  cmd_t       cmd;
  sts_t       sts;
  logic [4:0] step_x, step_y;

  gaps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gaps_dp #(
    .GRID_SIDE  (GRID_SIDE),
    .LIST_DEPTH (LIST_DEPTH),
    .MAX_PATH   (MAX_PATH),
    .STEP_COST  (STEP_COST)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cell_x_i       (s_axis_tdata_i[4:0]),
    .cell_y_i       (s_axis_tdata_i[9:5]),
    .cell_blocked_i (s_axis_tdata_i[10]),
    .start_x_i      (s_axis_tdata_i[15:11]),
    .start_y_i      (s_axis_tdata_i[20:16]),
    .goal_x_i       (s_axis_tdata_i[25:21]),
    .goal_y_i       (s_axis_tdata_i[30:26]),
    .out_ready_i    (m_axis_tready_i),
    .out_valid_o    (m_axis_tvalid_o),
    .step_x_o       (step_x),
    .step_y_o       (step_y),
    .last_o         (m_axis_tlast_o),
    .status_o       (m_axis_tuser_o)
  );

  // Input ready and the packed result transfer
  assign s_axis_tready_o = cmd.in_ready;
  assign m_axis_tdata_o  = {6'b0, step_y, step_x};

endmodule

`default_nettype wire

FILE: dv/path_search_checker.sv
// Path search checker: watches both streams of grid_astar_path_search, keeps its own
// tile map, plans each route in software and compares the emitted steps in order.
// Depends on gaps_pkg for the status codes.
`default_nettype none

module path_search_checker import gaps_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [31:0] s_data_i,
  input  wire logic        s_user_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [15:0] m_data_i,
  input  wire logic [2:0]  m_user_i,
  input  wire logic        m_last_i,
  output int               fail_cnt_o,
  output int               pending_o
);

  localparam bit FN_MAP_WR = 1'b0;
  localparam bit FN_SEARCH = 1'b1;
  localparam int SIDE      = 32;
  localparam int SLOTS     = 256;
  localparam int PATH_MAX  = 64;
  localparam int MOVE_COST = 10;

  typedef struct {
    logic [4:0] x;
    logic [4:0] y;
    logic       last;
    status_e    st;
  } route_step_t;

  route_step_t route_q[$];
  bit tile_blocked[SIDE*SIDE];

  // Open and closed node lists
  int o_x[SLOTS], o_y[SLOTS], o_px[SLOTS], o_py[SLOTS], o_g[SLOTS], o_f[SLOTS];
  bit o_used[SLOTS];
  int c_x[SLOTS], c_y[SLOTS], c_px[SLOTS], c_py[SLOTS];
  bit c_used[SLOTS];

  function automatic int manhattan_cost(int ax, int ay, int bx, int by);
    return ((ax > bx ? ax - bx : bx - ax) + (ay > by ? ay - by : by - ay)) * MOVE_COST;
  endfunction

  function automatic int find_open(int x, int y);
    for (int i = 0; i < SLOTS; i++)
      if (o_used[i] && o_x[i] == x && o_y[i] == y) return i;
    return -1;
  endfunction

  function automatic int find_closed(int x, int y);
    for (int i = 0; i < SLOTS; i++)
      if (c_used[i] && c_x[i] == x && c_y[i] == y) return i;
    return -1;
  endfunction

  function automatic void push_status(status_e st);
    route_step_t r;
    r.x = '0;
    r.y = '0;
    r.last = 1'b1;
    r.st = st;
    route_q.push_back(r);
  endfunction

  // Plan one route and queue the steps it should produce
  function automatic void plan_route(int sx, int sy, int gx, int gy);
    int ddx[4] = '{0, 1, 0, -1};
    int ddy[4] = '{1, 0, -1, 0};
    int ci, c, p, nx, ny, ng, n;
    int cx, cy, cpx, cpy, cg;
    int bx[PATH_MAX], by[PATH_MAX];
    route_step_t r;
    if (sx == gx && sy == gy) begin
      push_status(ST_SAME);
      return;
    end
    for (int i = 0; i < SLOTS; i++) begin
      o_used[i] = 1'b0;
      c_used[i] = 1'b0;
    end
    o_x[0] = sx; o_y[0] = sy; o_px[0] = sx; o_py[0] = sy;
    o_g[0] = 0;
    o_f[0] = manhattan_cost(sx, sy, gx, gy);
    o_used[0] = 1'b1;
    forever begin
      // Expand the cheapest open node, lowest slot on a tie
      ci = -1;
      for (int i = 0; i < SLOTS; i++)
        if (o_used[i] && (ci < 0 || o_f[i] < o_f[ci])) ci = i;
      if (ci < 0) begin
        push_status(ST_UNREACH);
        return;
      end
      cx = o_x[ci]; cy = o_y[ci]; cpx = o_px[ci]; cpy = o_py[ci]; cg = o_g[ci];
      o_used[ci] = 1'b0;
      c = -1;
      for (int i = 0; i < SLOTS; i++)
        if (c < 0 && !c_used[i]) c = i;
      if (c < 0) begin
        push_status(ST_OVERFLOW);
        return;
      end
      c_x[c] = cx; c_y[c] = cy; c_px[c] = cpx; c_py[c] = cpy; c_used[c] = 1'b1;
      if (cx == gx && cy == gy) break;
      for (int k = 0; k < 4; k++) begin
        nx = cx + ddx[k];
        ny = cy + ddy[k];
        ng = cg + MOVE_COST;
        if (nx < 0 || ny < 0 || nx >= SIDE || ny >= SIDE) continue;
        if (tile_blocked[ny*SIDE+nx] || find_closed(nx, ny) >= 0) continue;
        p = find_open(nx, ny);
        if (p < 0) begin
          for (int i = 0; i < SLOTS; i++)
            if (p < 0 && !o_used[i]) p = i;
          if (p < 0) begin
            push_status(ST_OVERFLOW);
            return;
          end
          o_x[p] = nx; o_y[p] = ny; o_px[p] = cx; o_py[p] = cy;
          o_g[p] = ng;
          o_f[p] = ng + manhattan_cost(nx, ny, gx, gy);
          o_used[p] = 1'b1;
        end else if (ng < o_g[p]) begin
          o_f[p] = o_f[p] - o_g[p] + ng;
          o_g[p] = ng;
          o_px[p] = cx;
          o_py[p] = cy;
        end
      end
    end
    // Walk parents back from the goal
    n = 0;
    while (!(cx == sx && cy == sy)) begin
      if (n >= PATH_MAX) begin
        push_status(ST_TOOLONG);
        return;
      end
      bx[n] = cx;
      by[n] = cy;
      n++;
      p = find_closed(cpx, cpy);
      if (p < 0) begin
        push_status(ST_UNREACH);
        return;
      end
      cx = c_x[p]; cy = c_y[p]; cpx = c_px[p]; cpy = c_py[p];
    end
    if (n == 0) begin
      push_status(ST_UNREACH);
      return;
    end
    for (int k = 0; k < n; k++) begin
      r.x = bx[n-1-k];
      r.y = by[n-1-k];
      r.last = (k == n - 1);
      r.st = ST_STEP;
      route_q.push_back(r);
    end
  endfunction

  // Track input transfers and check output transfers
  always @(posedge clk_i or negedge rst_ni) begin
    route_step_t e;
    if (!rst_ni) begin
      for (int i = 0; i < SIDE*SIDE; i++) tile_blocked[i] = 1'b0;
      route_q.delete();
      fail_cnt_o = 0;
      pending_o = 0;
    end else begin
      if (s_valid_i && s_ready_i) begin
        if (s_user_i == FN_SEARCH)
          plan_route(s_data_i[15:11], s_data_i[20:16], s_data_i[25:21], s_data_i[30:26]);
        else if (s_user_i == FN_MAP_WR)
          tile_blocked[s_data_i[9:5]*SIDE + s_data_i[4:0]] = s_data_i[10];
      end
      if (m_valid_i && m_ready_i) begin
        if (route_q.size() == 0) begin
          fail_cnt_o++;
          if (fail_cnt_o <= 10)
            $display("unexpected step: x=%0d y=%0d last=%0d status=%0d",
                     m_data_i[4:0], m_data_i[9:5], m_last_i, m_user_i);
        end else begin
          e = route_q.pop_front();
          if (m_data_i[4:0] !== e.x || m_data_i[9:5] !== e.y || m_data_i[15:10] !== '0 ||
              m_last_i !== e.last || m_user_i !== e.st) begin
            fail_cnt_o++;
            if (fail_cnt_o <= 10)
              $display({"step mismatch: exp x=%0d y=%0d last=%0d status=%0d, ",
                        "got data=%h last=%0d status=%0d"},
                       e.x, e.y, e.last, e.st, m_data_i, m_last_i, m_user_i);
          end
        end
      end
      pending_o = route_q.size();
    end
  end

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Testbench top for grid_astar_path_search: drives map writes and route searches
// with random gaps and receiver stalls, and reports the verdict of the checker.
// Depends on gaps_pkg, grid_astar_path_search and path_search_checker.
`default_nettype none

module tb;

  localparam bit FN_MAP_WR = 1'b0;
  localparam bit FN_SEARCH = 1'b1;

  logic        clk;
  logic        rst_n;
  logic        s_valid;
  logic        s_ready;
  logic [31:0] s_data;
  logic        s_user;
  logic        m_valid;
  logic        m_ready;
  logic [15:0] m_data;
  logic [2:0]  m_user;
  logic        m_last;
  int          fail_cnt;
  int          pending;
  int          steps_taken;
  bit          burst;

  grid_astar_path_search uut (
    .clk_i(clk), .rst_ni(rst_n),
    .s_axis_tvalid_i(s_valid), .s_axis_tready_o(s_ready),
    .s_axis_tdata_i(s_data), .s_axis_tuser_i(s_user),
    .m_axis_tvalid_o(m_valid), .m_axis_tready_i(m_ready),
    .m_axis_tdata_o(m_data), .m_axis_tuser_o(m_user), .m_axis_tlast_o(m_last)
  );

  path_search_checker chk (
    .clk_i(clk), .rst_ni(rst_n),
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data), .s_user_i(s_user),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data), .m_user_i(m_user),
    .m_last_i(m_last), .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Hard stop
  initial begin
    repeat (30) #120000000;
    $display("FAIL grid_astar_path_search");
    $finish;
  end

  // Offer one item after a random gap, or none in a burst; call and return at a falling edge
  task automatic offer_item(bit fn, logic [30:0] payload);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_data = {1'b0, payload};
    s_user = fn;
    s_valid = 1'b1;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  task automatic write_cell(int x, int y, bit blk);
    offer_item(FN_MAP_WR, {20'($urandom_range(0, 1048575)), blk, y[4:0], x[4:0]});
  endtask

  task automatic find_route(int sx, int sy, int gx, int gy);
    offer_item(FN_SEARCH, {gy[4:0], gx[4:0], sy[4:0], sx[4:0], 11'($urandom)});
  endtask

  function automatic int clamp_tile(int v);
    return v < 4 ? 4 : (v > 31 ? 31 : v);
  endfunction

  function automatic int clamp_row(int v);
    return v < 0 ? 0 : (v > 31 ? 31 : v);
  endfunction

  // Receiver: random stalls, burst stretches, and one long hold-off
  initial begin
    int n;
    bit held;
    m_ready = 1'b0;
    held = 1'b0;
    steps_taken = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!held && steps_taken >= 20) begin
        held = 1'b1;
        m_ready = 1'b0;
        repeat (4000) @(negedge clk);
      end
      n = burst ? 0 : $urandom_range(0, 13);
      if (n > 0) begin
        m_ready = 1'b0;
        repeat (n) @(negedge clk);
      end
      m_ready = 1'b1;
      do @(posedge clk); while (!m_valid);
      steps_taken++;
    end
  end

  // Stimulus and verdict
  initial begin
    int sx, sy;
    s_valid = 1'b0;
    s_data = '0;
    s_user = FN_MAP_WR;
    burst = 1'b0;
    rst_n = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Start equals goal at two corners, then plain searches across the grid
    find_route(0, 0, 0, 0);
    find_route(31, 31, 31, 31);
    find_route(31, 0, 5, 31);
    find_route(7, 7, 9, 6);
    // Blocked start is still expanded
    write_cell(31, 31, 1'b1);
    find_route(31, 31, 29, 30);
    // Enclose one tile: unreachable from inside, list overflow from outside
    write_cell(20, 21, 1'b1);
    write_cell(21, 20, 1'b1);
    write_cell(20, 19, 1'b1);
    write_cell(19, 20, 1'b1);
    find_route(20, 20, 25, 25);
    find_route(14, 14, 20, 20);
    write_cell(20, 21, 1'b0);
    write_cell(21, 20, 1'b0);
    write_cell(20, 19, 1'b0);
    write_cell(19, 20, 1'b0);
    write_cell(31, 31, 1'b0);
    // Serpentine corridor: a path too long, then a short one inside it
    for (int y = 0; y <= 30; y++) write_cell(1, y, 1'b1);
    for (int y = 1; y <= 31; y++) write_cell(3, y, 1'b1);
    find_route(0, 0, 4, 0);
    find_route(0, 5, 0, 0);

    // Random part: sparse obstacles and short searches right of the corridor
    for (int i = 0; i < 100; i++) begin
      if (i % 30 == 0) burst = ~burst;
      if ($urandom_range(0, 99) < 55) begin
        if ($urandom_range(0, 3) == 0)
          write_cell($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 2) == 0);
        else
          write_cell($urandom_range(4, 23), $urandom_range(4, 23), $urandom_range(0, 2) == 0);
      end else begin
        sx = $urandom_range(4, 31);
        sy = $urandom_range(0, 31);
        if ($urandom_range(0, 9) == 0)
          find_route(sx, sy, sx, sy);
        else
          find_route(sx, sy, clamp_tile(sx + int'($urandom_range(0, 10)) - 5),
                     clamp_row(sy + int'($urandom_range(0, 10)) - 5));
      end
    end
    s_valid = 1'b0;
    burst = 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (fail_cnt == 0 && pending == 0) begin
      $display("PASS grid_astar_path_search");
    end else begin
      $display("FAIL grid_astar_path_search");
    end
    $finish;
  end

endmodule

`default_nettype wire
